### rtl/slcs_pkg.sv
// Shared types, register codes and the fractional power-of-two table for the light selector.
`default_nettype none
package slcs_pkg;

    localparam logic [2:0] REG_SHADOWS_ENABLED    = 3'd0;
    localparam logic [2:0] REG_CAP_ENABLED        = 3'd1;
    localparam logic [2:0] REG_CAP_SPOT           = 3'd2;
    localparam logic [2:0] REG_CAP_POINT          = 3'd3;
    localparam logic [2:0] REG_CAP_HYSTERESIS     = 3'd4;
    localparam logic [2:0] REG_CLASS_HYSTERESIS   = 3'd5;
    localparam logic [2:0] REG_BASE_CLASS         = 3'd6;
    localparam logic [2:0] REG_COVERAGE_REFERENCE = 3'd7;

    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic               is_point;
        logic [15:0]        light_index;
        logic               visible;
        logic               pinned;
        logic [15:0]        coverage;
        logic signed [15:0] intensity;
        logic signed [7:0]  priority_req;
        logic               last;
    } cand_t;

    typedef struct packed {
        logic        has_light;
        logic        kind_out;
        logic [15:0] index_out;
        logic [47:0] score_out;
        logic [2:0]  size_class_out;
        logic [5:0]  spot_total;
        logic [5:0]  point_total;
        logic [5:0]  dropped_total;
        logic        last_out;
    } sel_t;

    typedef struct packed {
        logic        pin;
        logic [2:0]  cls;
        logic [16:0] key;
        logic [47:0] rank;
        logic [47:0] score;
    } cand_rec_t;

    typedef struct packed {
        logic [16:0] key;
        logic [2:0]  cls;
        logic [47:0] score;
    } kept_rec_t;

    typedef struct packed {
        logic        en;
        logic [47:0] a;
        logic [16:0] b;
    } mul_req_t;

    function automatic logic [16:0] exp2frac(input logic [3:0] f);
        logic [16:0] v;
        case (f)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd68438;
            4'd2:    v = 17'd71468;
            4'd3:    v = 17'd74632;
            4'd4:    v = 17'd77936;
            4'd5:    v = 17'd81386;
            4'd6:    v = 17'd84990;
            4'd7:    v = 17'd88752;
            4'd8:    v = 17'd92682;
            4'd9:    v = 17'd96785;
            4'd10:   v = 17'd101070;
            4'd11:   v = 17'd105545;
            4'd12:   v = 17'd110218;
            4'd13:   v = 17'd115098;
            4'd14:   v = 17'd120194;
            default: v = 17'd125515;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/shadow_light_cap_selector_core.sv
// Top level of the shadow light selector: sequencer, candidate store and history.
// Each visible candidate word is looked up in the previous frame's kept list, searched entry by
// entry until a match through the one read port of the history RAM, then scored (with a
// hysteresis step when the light was kept) and written to the candidate store; words that are not
// visible, or that arrive once the candidate store is full, are not stored. The word marked last
// also closes the frame: after a set-up state, when shadows are enabled, with caps on n candidates
// are ordered by n selection passes over the candidate RAM, with caps off one pass copies them.
// Each result word is then held until the sink does not stall. The score and the size class share
// one registered 48 by 17 bit multiplier.
`default_nettype none
module shadow_light_cap_selector_core #(
    parameter int MAX_CANDIDATES   = 32,
    parameter int SIZE_CLASS_COUNT = 8,
    parameter int PRIORITY_MIN     = -128,
    parameter int PRIORITY_MAX     = 127
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [15:0]     cfg_data,
    input  wire logic            cand_valid,
    output logic                 cand_stall,
    input  wire slcs_pkg::cand_t cand,
    output logic                 sel_valid,
    input  wire logic            sel_stall,
    output slcs_pkg::sel_t       sel
);

    localparam int IW = $clog2(MAX_CANDIDATES);
    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam int BASE_LIM = (SIZE_CLASS_COUNT - 1 > 7) ? 7 : SIZE_CLASS_COUNT - 1;
    localparam logic signed [7:0] PMIN_S = 8'(PRIORITY_MIN);
    localparam logic signed [7:0] PMAX_S = 8'(PRIORITY_MAX);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LK_RD   = 4'd1;
    localparam logic [3:0] ST_LK_CMP  = 4'd2;
    localparam logic [3:0] ST_M0      = 4'd3;
    localparam logic [3:0] ST_M1      = 4'd4;
    localparam logic [3:0] ST_M2      = 4'd5;
    localparam logic [3:0] ST_SC      = 4'd6;
    localparam logic [3:0] ST_M3      = 4'd7;
    localparam logic [3:0] ST_M4      = 4'd8;
    localparam logic [3:0] ST_WR      = 4'd9;
    localparam logic [3:0] ST_FIN     = 4'd10;
    localparam logic [3:0] ST_SCAN    = 4'd11;
    localparam logic [3:0] ST_PICK    = 4'd12;
    localparam logic [3:0] ST_EM_RD   = 4'd13;
    localparam logic [3:0] ST_EM_LD   = 4'd14;
    localparam logic [3:0] ST_EM_WAIT = 4'd15;

    logic        shadows_enabled_reg;
    logic        cap_enabled_reg;
    logic [5:0]  cap_spot_reg;
    logic [5:0]  cap_point_reg;
    logic [7:0]  cap_hysteresis_reg;
    logic [7:0]  class_hysteresis_reg;
    logic [2:0]  base_class_reg;
    logic [15:0] coverage_reference_reg;

    logic [3:0]          state_reg, state_next;
    slcs_pkg::cand_t     item_reg, item_next;
    logic [CW-1:0]       cand_cnt_reg, cand_cnt_next;
    logic [CW-1:0]       prev_cnt_reg, prev_cnt_next;
    logic [CW-1:0]       lk_idx_reg, lk_idx_next;
    logic                found_reg, found_next;
    logic [2:0]          pc_reg, pc_next;
    logic [47:0]         score_reg, score_next;
    logic [47:0]         rank_reg, rank_next;
    logic [CW-1:0]       scan_addr_reg, scan_addr_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [CW-1:0]       round_reg, round_next;
    logic [MAX_CANDIDATES-1:0] taken_reg, taken_next;
    logic                best_vld_reg, best_vld_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    slcs_pkg::cand_rec_t best_reg, best_next;
    logic [CW-1:0]       nk_reg, nk_next;
    logic [CW-1:0]       spots_reg, spots_next;
    logic [CW-1:0]       points_reg, points_next;
    logic [CW-1:0]       dropped_reg, dropped_next;
    logic [CW-1:0]       em_idx_reg, em_idx_next;
    slcs_pkg::sel_t      sel_reg, sel_next;
    logic                sel_valid_reg, sel_valid_next;

    logic                cand_we;
    logic [IW-1:0]       cand_raddr;
    slcs_pkg::cand_rec_t cand_wdata;
    slcs_pkg::cand_rec_t cand_rdata;
    logic                kept_we;
    logic [IW-1:0]       kept_waddr;
    logic [IW-1:0]       kept_raddr;
    slcs_pkg::kept_rec_t kept_wdata;
    slcs_pkg::kept_rec_t kept_rdata;
    slcs_pkg::mul_req_t  mul_req;
    logic [64:0]         prod;

    logic [15:0]         mag;
    logic signed [7:0]   p_cl;
    logic [7:0]          q;
    logic [5:0]          shamt;
    logic [64:0]         shifted;
    logic [47:0]         score_sat;
    logic [48:0]         rank_sum;
    logic [47:0]         rank_sat;
    logic [2:0]          base;
    logic [2:0]          demand;
    logic [2:0]          held;
    logic [8:0]          m9;
    logic                promote;
    logic [22:0]         c_pro;
    logic [22:0]         c_dem;
    logic                pro_ok;
    logic                dem_ok;
    logic [2:0]          cls_final;
    logic [16:0]         item_key;
    logic                better;
    logic [CW-1:0]       kind_cnt;
    logic [5:0]          kind_cap;

    slcs_ram #(
        .WIDTH($bits(slcs_pkg::cand_rec_t)),
        .DEPTH(MAX_CANDIDATES)
    ) u_cand_ram (
        .clk  (clk),
        .we   (cand_we),
        .waddr(cand_cnt_reg[IW-1:0]),
        .wdata(cand_wdata),
        .raddr(cand_raddr),
        .rdata(cand_rdata)
    );

    slcs_ram #(
        .WIDTH($bits(slcs_pkg::kept_rec_t)),
        .DEPTH(MAX_CANDIDATES)
    ) u_kept_ram (
        .clk  (clk),
        .we   (kept_we),
        .waddr(kept_waddr),
        .wdata(kept_wdata),
        .raddr(kept_raddr),
        .rdata(kept_rdata)
    );

    slcs_mul u_mul (
        .clk (clk),
        .req (mul_req),
        .prod(prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadows_enabled_reg    <= 1'b1;
            cap_enabled_reg        <= 1'b1;
            cap_spot_reg           <= 6'd8;
            cap_point_reg          <= 6'd8;
            cap_hysteresis_reg     <= 8'd0;
            class_hysteresis_reg   <= 8'd0;
            base_class_reg         <= 3'd7;
            coverage_reference_reg <= 16'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slcs_pkg::REG_SHADOWS_ENABLED:    shadows_enabled_reg    <= cfg_data[0];
                slcs_pkg::REG_CAP_ENABLED:        cap_enabled_reg        <= cfg_data[0];
                slcs_pkg::REG_CAP_SPOT:           cap_spot_reg           <= cfg_data[5:0];
                slcs_pkg::REG_CAP_POINT:          cap_point_reg          <= cfg_data[5:0];
                slcs_pkg::REG_CAP_HYSTERESIS:     cap_hysteresis_reg     <= cfg_data[7:0];
                slcs_pkg::REG_CLASS_HYSTERESIS:   class_hysteresis_reg   <= cfg_data[7:0];
                slcs_pkg::REG_BASE_CLASS:         base_class_reg         <= cfg_data[2:0];
                slcs_pkg::REG_COVERAGE_REFERENCE: coverage_reference_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Score, boost and size class arithmetic around the shared multiplier.
    always_comb
    begin
        mag = item_reg.intensity[15] ? (~item_reg.intensity + 16'd1) : item_reg.intensity;
        if (item_reg.priority_req < PMIN_S)
        begin
            p_cl = PMIN_S;
        end
        else if (item_reg.priority_req > PMAX_S)
        begin
            p_cl = PMAX_S;
        end
        else
        begin
            p_cl = item_reg.priority_req;
        end
        q         = {~p_cl[7], p_cl[6:0]};
        shamt     = 6'd32 - {2'd0, q[7:4]};
        shifted   = prod >> shamt;
        score_sat = (|shifted[64:48]) ? slcs_pkg::SAT48 : shifted[47:0];
        rank_sum  = {1'b0, score_reg} + {1'b0, prod[55:8]};
        rank_sat  = rank_sum[48] ? slcs_pkg::SAT48 : rank_sum[47:0];

        base = (base_class_reg > 3'(BASE_LIM)) ? 3'(BASE_LIM) : base_class_reg;
        demand = 3'd0;
        if (item_reg.coverage != 16'd0)
        begin
            for (int k = 7; k >= 0; k--)
            begin
                if ((3'(k) <= base) &&
                    ((23'(item_reg.coverage) << k) >= 23'(coverage_reference_reg)))
                begin
                    demand = base - 3'(k);
                end
            end
        end
        held    = (pc_reg < base) ? pc_reg : base;
        m9      = 9'd256 + {1'b0, class_hysteresis_reg};
        promote = demand > held;
        c_pro   = 23'(item_reg.coverage) << (base - held - 3'd1);
        c_dem   = 23'(item_reg.coverage) << (base - held);
        pro_ok  = {c_pro, 8'd0} >= 31'(prod[24:0]);
        dem_ok  = prod[31:0] <= {8'd0, coverage_reference_reg, 8'd0};
        if (!found_reg || demand == held)
        begin
            cls_final = found_reg ? held : demand;
        end
        else if (promote)
        begin
            cls_final = pro_ok ? demand : held;
        end
        else
        begin
            cls_final = dem_ok ? demand : held;
        end
        item_key = {item_reg.is_point, item_reg.light_index};
    end

    // Ranking order: pinned first, then rank score descending, then key ascending.
    always_comb
    begin
        if (cand_rdata.pin != best_reg.pin)
        begin
            better = cand_rdata.pin;
        end
        else if (cand_rdata.rank != best_reg.rank)
        begin
            better = cand_rdata.rank > best_reg.rank;
        end
        else
        begin
            better = cand_rdata.key < best_reg.key;
        end
        kind_cnt = best_reg.key[16] ? points_reg : spots_reg;
        kind_cap = best_reg.key[16] ? cap_point_reg : cap_spot_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cand_cnt_next  = cand_cnt_reg;
        prev_cnt_next  = prev_cnt_reg;
        lk_idx_next    = lk_idx_reg;
        found_next     = found_reg;
        pc_next        = pc_reg;
        score_next     = score_reg;
        rank_next      = rank_reg;
        scan_addr_next = scan_addr_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        round_next     = round_reg;
        taken_next     = taken_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        nk_next        = nk_reg;
        spots_next     = spots_reg;
        points_next    = points_reg;
        dropped_next   = dropped_reg;
        em_idx_next    = em_idx_reg;
        sel_next       = sel_reg;
        sel_valid_next = sel_valid_reg;

        cand_we        = 1'b0;
        cand_raddr     = scan_addr_reg[IW-1:0];
        cand_wdata     = '{pin: item_reg.pinned, cls: cls_final, key: item_key,
                           rank: rank_reg, score: score_reg};
        kept_we        = 1'b0;
        kept_waddr     = nk_reg[IW-1:0];
        kept_wdata     = '{key: cand_rdata.key, cls: cand_rdata.cls, score: cand_rdata.score};
        kept_raddr     = lk_idx_reg[IW-1:0];
        mul_req        = '{en: 1'b0, a: 48'd0, b: 17'd0};

        case (state_reg)
            ST_IDLE:
            begin
                if (cand_valid)
                begin
                    item_next  = cand;
                    found_next = 1'b0;
                    pc_next    = 3'd0;
                    lk_idx_next = '0;
                    if (cand.visible && cand_cnt_reg < CW'(MAX_CANDIDATES))
                    begin
                        state_next = (prev_cnt_reg != '0) ? ST_LK_RD : ST_M0;
                    end
                    else if (cand.last)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_LK_RD:
            begin
                state_next = ST_LK_CMP;
            end
            ST_LK_CMP:
            begin
                if (kept_rdata.key == item_key)
                begin
                    found_next = 1'b1;
                    pc_next    = kept_rdata.cls;
                    state_next = ST_M0;
                end
                else
                begin
                    lk_idx_next = lk_idx_reg + 1'b1;
                    state_next  = (lk_idx_reg + 1'b1 == prev_cnt_reg) ? ST_M0 : ST_LK_RD;
                end
            end
            ST_M0:
            begin
                mul_req    = '{en: 1'b1, a: 48'(mag), b: 17'(item_reg.coverage)};
                state_next = ST_M1;
            end
            ST_M1:
            begin
                mul_req    = '{en: 1'b1, a: 48'(prod[31:0]), b: 17'(item_reg.coverage)};
                state_next = ST_M2;
            end
            ST_M2:
            begin
                mul_req    = '{en: 1'b1, a: 48'(prod[47:8]), b: slcs_pkg::exp2frac(q[3:0])};
                state_next = ST_SC;
            end
            ST_SC:
            begin
                score_next = score_sat;
                state_next = found_reg ? ST_M3 : ST_M4;
            end
            ST_M3:
            begin
                mul_req    = '{en: 1'b1, a: score_reg, b: 17'(cap_hysteresis_reg)};
                state_next = ST_M4;
            end
            ST_M4:
            begin
                rank_next  = found_reg ? rank_sat : score_reg;
                mul_req    = '{en: 1'b1,
                               a: promote ? 48'(coverage_reference_reg) : 48'(c_dem),
                               b: 17'(m9)};
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cand_we       = 1'b1;
                cand_cnt_next = cand_cnt_reg + 1'b1;
                state_next    = item_reg.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                nk_next        = '0;
                spots_next     = '0;
                points_next    = '0;
                dropped_next   = '0;
                scan_addr_next = '0;
                rd_pend_next   = 1'b0;
                round_next     = '0;
                taken_next     = '0;
                best_vld_next  = 1'b0;
                em_idx_next    = '0;
                if (shadows_enabled_reg && cand_cnt_reg != '0)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EM_RD;
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = scan_addr_reg < cand_cnt_reg;
                rd_idx_next  = scan_addr_reg[IW-1:0];
                if (scan_addr_reg < cand_cnt_reg)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (!cap_enabled_reg)
                    begin
                        kept_we = 1'b1;
                        nk_next = nk_reg + 1'b1;
                        if (cand_rdata.key[16])
                        begin
                            points_next = points_reg + 1'b1;
                        end
                        else
                        begin
                            spots_next = spots_reg + 1'b1;
                        end
                    end
                    else if (!taken_reg[rd_idx_reg] && (!best_vld_reg || better))
                    begin
                        best_next     = cand_rdata;
                        best_idx_next = rd_idx_reg;
                        best_vld_next = 1'b1;
                    end
                end
                if (scan_addr_reg == cand_cnt_reg && !rd_pend_reg)
                begin
                    state_next = cap_enabled_reg ? ST_PICK : ST_EM_RD;
                end
            end
            ST_PICK:
            begin
                taken_next[best_idx_reg] = 1'b1;
                kept_wdata = '{key: best_reg.key, cls: best_reg.cls, score: best_reg.score};
                if (!best_reg.pin && 7'(kind_cnt) >= 7'(kind_cap))
                begin
                    dropped_next = dropped_reg + 1'b1;
                end
                else
                begin
                    kept_we = 1'b1;
                    nk_next = nk_reg + 1'b1;
                    if (best_reg.key[16])
                    begin
                        points_next = points_reg + 1'b1;
                    end
                    else
                    begin
                        spots_next = spots_reg + 1'b1;
                    end
                end
                round_next     = round_reg + 1'b1;
                scan_addr_next = '0;
                best_vld_next  = 1'b0;
                state_next     = (round_reg + 1'b1 == cand_cnt_reg) ? ST_EM_RD : ST_SCAN;
            end
            ST_EM_RD:
            begin
                prev_cnt_next = nk_reg;
                cand_cnt_next = '0;
                kept_raddr    = em_idx_reg[IW-1:0];
                state_next    = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                sel_next.has_light      = nk_reg != '0;
                sel_next.kind_out       = (nk_reg != '0) ? kept_rdata.key[16] : 1'b0;
                sel_next.index_out      = (nk_reg != '0) ? kept_rdata.key[15:0] : 16'd0;
                sel_next.score_out      = (nk_reg != '0) ? kept_rdata.score : 48'd0;
                sel_next.size_class_out = (nk_reg != '0) ? kept_rdata.cls : 3'd0;
                sel_next.spot_total     = 6'(spots_reg);
                sel_next.point_total    = 6'(points_reg);
                sel_next.dropped_total  = 6'(dropped_reg);
                sel_next.last_out       = (nk_reg == '0) || (em_idx_reg + 1'b1 == nk_reg);
                sel_valid_next          = 1'b1;
                state_next              = ST_EM_WAIT;
            end
            ST_EM_WAIT:
            begin
                if (!sel_stall)
                begin
                    sel_valid_next = 1'b0;
                    em_idx_next    = em_idx_reg + 1'b1;
                    state_next     = sel_reg.last_out ? ST_IDLE : ST_EM_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cand_cnt_reg  <= '0;
            prev_cnt_reg  <= '0;
            lk_idx_reg    <= '0;
            found_reg     <= 1'b0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            round_reg     <= '0;
            taken_reg     <= '0;
            best_vld_reg  <= 1'b0;
            nk_reg        <= '0;
            em_idx_reg    <= '0;
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cand_cnt_reg  <= cand_cnt_next;
            prev_cnt_reg  <= prev_cnt_next;
            lk_idx_reg    <= lk_idx_next;
            found_reg     <= found_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            round_reg     <= round_next;
            taken_reg     <= taken_next;
            best_vld_reg  <= best_vld_next;
            nk_reg        <= nk_next;
            em_idx_reg    <= em_idx_next;
            sel_valid_reg <= sel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pc_reg       <= pc_next;
        score_reg    <= score_next;
        rank_reg     <= rank_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        spots_reg    <= spots_next;
        points_reg   <= points_next;
        dropped_reg  <= dropped_next;
        sel_reg      <= sel_next;
    end

    assign cand_stall = state_reg != ST_IDLE;
    assign sel_valid  = sel_valid_reg;
    assign sel        = sel_reg;

endmodule
`default_nettype wire

### rtl/slcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module slcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/slcs_mul.sv
// Shared 48 by 17 bit multiplier with a registered product.
`default_nettype none
module slcs_mul (
    input  wire logic               clk,
    input  wire slcs_pkg::mul_req_t req,
    output logic [64:0]             prod
);

    logic [64:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= {17'd0, req.a} * {48'd0, req.b};
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire
